[src/pid_pkg.sv]
`default_nettype none

package pid_pkg;

    // Field and datapath widths
    localparam int InW    = 16;
    localparam int CfgW   = 16;
    localparam int ErrW   = 17;
    localparam int DiffW  = 18;
    localparam int MulAW  = 35;
    localparam int MulBW  = 18;
    localparam int ProdW  = MulAW + MulBW;
    localparam int AccW   = 54;
    localparam int OutW   = 32;
    localparam int SatW   = 44;
    localparam int StepW  = 3;
    localparam int CfgIdxW = 3;
    localparam int RoundShift = 12;

    // Configuration reset values
    localparam logic [CfgW-1:0] KpReset  = 16'd205;
    localparam logic [CfgW-1:0] KiReset  = 16'd51;
    localparam logic [CfgW-1:0] KdReset  = 16'd26;
    localparam logic [CfgW-1:0] DtReset  = 16'd6554;
    localparam logic [CfgW-1:0] RdtReset = 16'd2560;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_KP,
        CFG_KI,
        CFG_KD,
        CFG_DT,
        CFG_RDT
    } cfg_index_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ERR_DT,
        MUL_INT_KI,
        MUL_ERR_KP,
        MUL_DIFF_RDT,
        MUL_PROD_KD
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        SHIFT_0,
        SHIFT_4,
        SHIFT_8
    } acc_shift_t;

    typedef enum logic [1:0] {
        JUMP_NONE,
        JUMP_DT_ZERO,
        JUMP_RDT_ZERO
    } jump_cond_t;

    typedef struct packed {
        mul_sel_t          mul_sel;
        acc_op_t           acc_op;
        acc_shift_t        acc_shift;
        logic              integ_en;
        logic              finish;
        jump_cond_t        jump_cond;
        logic [StepW-1:0]  jump_target;
    } ctrl_word_t;

    typedef struct packed {
        logic dt_zero;
        logic rdt_zero;
    } dp_status_t;

    typedef struct packed {
        logic signed [CfgW-1:0] kp;
        logic signed [CfgW-1:0] ki;
        logic signed [CfgW-1:0] kd;
        logic [CfgW-1:0]        dt;
        logic [CfgW-1:0]        rdt;
    } cfg_regs_t;

    localparam ctrl_word_t CtrlNop = '{MUL_NONE, ACC_HOLD, SHIFT_0, 1'b0, 1'b0, JUMP_NONE, '0};

    // Microprogram: one control word per step.
    function automatic ctrl_word_t ucode_rom(input logic [StepW-1:0] step);
        ctrl_word_t w;
        w = CtrlNop;
        unique case (step)
            3'd0:
            begin
                // error * dt; with a zero time step the integral is left alone
                w.mul_sel     = MUL_ERR_DT;
                w.jump_cond   = JUMP_DT_ZERO;
                w.jump_target = 3'd2;
            end
            3'd1:
            begin
                w.integ_en = 1'b1;
            end
            3'd2:
            begin
                w.mul_sel = MUL_INT_KI;
            end
            3'd3:
            begin
                w.acc_op    = ACC_LOAD;
                w.acc_shift = SHIFT_4;
                w.mul_sel   = MUL_ERR_KP;
            end
            3'd4:
            begin
                // A zero reciprocal leaves no derivative term, so skip it
                w.acc_op      = ACC_ADD;
                w.acc_shift   = SHIFT_8;
                w.mul_sel     = MUL_DIFF_RDT;
                w.jump_cond   = JUMP_RDT_ZERO;
                w.jump_target = 3'd7;
            end
            3'd5:
            begin
                w.mul_sel = MUL_PROD_KD;
            end
            3'd6:
            begin
                w.acc_op    = ACC_ADD;
                w.acc_shift = SHIFT_0;
            end
            3'd7:
            begin
                w.finish = 1'b1;
            end
            default:
            begin
                w = CtrlNop;
            end
        endcase
        return w;
    endfunction

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [OutW-1:0] sat32(input logic signed [SatW-1:0] v);
        logic signed [SatW-1:0] top;
        logic signed [SatW-1:0] bottom;
        top    = SatW'(signed'({1'b0, {(OutW-1){1'b1}}}));
        bottom = SatW'(signed'({1'b1, {(OutW-1){1'b0}}}));
        if (v > top)
        begin
            return top[OutW-1:0];
        end
        else if (v < bottom)
        begin
            return bottom[OutW-1:0];
        end
        return v[OutW-1:0];
    endfunction

endpackage

`default_nettype wire

[src/pid_step_if.sv]
`default_nettype none

// Input channel: one setpoint and one measured sample per beat.
interface pid_in_if;
    logic                    valid;
    logic                    ready;
    logic signed [15:0]      target_value;
    logic signed [15:0]      measured_value;

    modport source (output valid, output target_value, output measured_value, input ready);
    modport sink   (input valid, input target_value, input measured_value, output ready);
endinterface

// Output channel: controller drive and integral per beat.
interface pid_out_if;
    logic                    valid;
    logic                    ready;
    logic signed [31:0]      drive_value;
    logic signed [31:0]      integral_value;

    modport source (output valid, output drive_value, output integral_value, input ready);
    modport sink   (input valid, input drive_value, input integral_value, output ready);
endinterface

`default_nettype wire

[src/pid_seq.sv]
`default_nettype none

module pid_seq
    import pid_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       out_stall,
    input  dp_status_t      status,
    output ctrl_word_t      ctrl,
    output logic            ready
);

    logic [StepW-1:0] step_reg;
    logic [StepW-1:0] step_next;
    logic             busy_reg;
    logic             busy_next;
    ctrl_word_t       rom_word;
    logic             hold;
    logic             jump_taken;

    assign rom_word = ucode_rom(step_reg);

    // The final step waits while the previous result is still unread.
    assign hold  = rom_word.finish && out_stall;
    assign ready = !busy_reg || (rom_word.finish && !out_stall);

    // Jump condition decode
    always_comb
    begin
        unique case (rom_word.jump_cond)
            JUMP_NONE:     jump_taken = 1'b0;
            JUMP_DT_ZERO:  jump_taken = status.dt_zero;
            JUMP_RDT_ZERO: jump_taken = status.rdt_zero;
            default:       jump_taken = 1'b0;
        endcase
    end

    // Step counter and control word issue
    always_comb
    begin
        ctrl      = CtrlNop;
        step_next = step_reg;
        busy_next = busy_reg;
        if (busy_reg && !hold)
        begin
            ctrl = rom_word;
            if (rom_word.finish)
            begin
                busy_next = 1'b0;
                step_next = '0;
            end
            else if (jump_taken)
            begin
                step_next = rom_word.jump_target;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    // A new beat always starts the program at its first step.
    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg && step_reg == '0))
        else $error("program did not restart on an accepted beat");

    // An idle sequencer sits at step zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (step_reg == '0))
        else $error("idle sequencer left at a nonzero step");

    // Only the final step may end the program.
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !rom_word.finish) |=> busy_reg)
        else $error("program ended before its final step");

endmodule

`default_nettype wire

[src/pid_dp.sv]
`default_nettype none

module pid_dp
    import pid_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire logic signed [InW-1:0]   target_value,
    input  wire logic signed [InW-1:0]   measured_value,
    input  cfg_regs_t                    cfg,
    input  ctrl_word_t                   ctrl,
    output dp_status_t                   status,
    output logic signed [OutW-1:0]       drive_value,
    output logic signed [OutW-1:0]       integral_value
);

    logic signed [ErrW-1:0]   err_reg;
    logic signed [ErrW-1:0]   last_err_reg;
    logic signed [OutW-1:0]   integral_reg;
    logic signed [OutW-1:0]   integral_next;
    logic signed [ProdW-1:0]  prod_reg;
    logic signed [AccW-1:0]   acc_reg;
    logic signed [AccW-1:0]   acc_next;
    logic signed [OutW-1:0]   drive_reg;
    logic signed [OutW-1:0]   integral_out_reg;

    logic signed [DiffW-1:0]  diff;
    logic signed [MulAW-1:0]  mul_a;
    logic signed [MulBW-1:0]  mul_b;
    logic signed [ProdW-1:0]  mul_res;
    logic signed [ErrW+16:0]  inc_round;
    logic signed [SatW-1:0]   integ_sum;
    logic signed [AccW-1:0]   prod_ext;
    logic signed [AccW-1:0]   shifted;
    logic signed [AccW-1:0]   drive_round;
    logic signed [SatW-1:0]   drive_wide;

    assign status.dt_zero  = (cfg.dt == '0);
    assign status.rdt_zero = (cfg.rdt == '0);

    assign diff = DiffW'(err_reg) - DiffW'(last_err_reg);

    // Shared multiplier operand selection
    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_ERR_DT:
            begin
                mul_a = MulAW'(err_reg);
                mul_b = MulBW'(signed'({2'b00, cfg.dt}));
            end
            MUL_INT_KI:
            begin
                mul_a = MulAW'(integral_reg);
                mul_b = MulBW'(cfg.ki);
            end
            MUL_ERR_KP:
            begin
                mul_a = MulAW'(err_reg);
                mul_b = MulBW'(cfg.kp);
            end
            MUL_DIFF_RDT:
            begin
                mul_a = MulAW'(diff);
                mul_b = MulBW'(signed'({2'b00, cfg.rdt}));
            end
            MUL_PROD_KD:
            begin
                mul_a = prod_reg[MulAW-1:0];
                mul_b = MulBW'(cfg.kd);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_res = mul_a * mul_b;

    // Integral update: round error*dt from Q.16 to Q.4, add, saturate.
    assign inc_round = prod_reg[ErrW+16:0] + (ErrW+17)'(2 ** (RoundShift - 1));
    assign integ_sum = SatW'(integral_reg) + SatW'(signed'(inc_round[ErrW+16:RoundShift]));
    assign integral_next = sat32(integ_sum);

    // Accumulator shift and add
    assign prod_ext = AccW'(prod_reg);
    always_comb
    begin
        case (ctrl.acc_shift)
            SHIFT_4: shifted = prod_ext <<< 4;
            SHIFT_8: shifted = prod_ext <<< 8;
            default: shifted = prod_ext;
        endcase
        case (ctrl.acc_op)
            ACC_LOAD: acc_next = shifted;
            ACC_ADD:  acc_next = acc_reg + shifted;
            default:  acc_next = acc_reg;
        endcase
    end

    // Final rounding from Q.16 to Q.4 and saturation
    assign drive_round = acc_reg + AccW'(2 ** (RoundShift - 1));
    assign drive_wide  = SatW'(signed'(drive_round[AccW-1:RoundShift]));

    // Controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            last_err_reg <= '0;
        end
        else
        begin
            if (ctrl.integ_en)
            begin
                integral_reg <= integral_next;
            end
            if (ctrl.finish)
            begin
                last_err_reg <= err_reg;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg <= ErrW'(target_value) - ErrW'(measured_value);
        end
        if (ctrl.mul_sel != MUL_NONE)
        begin
            prod_reg <= mul_res;
        end
        acc_reg <= acc_next;
        if (ctrl.finish)
        begin
            drive_reg        <= sat32(drive_wide);
            integral_out_reg <= integral_reg;
        end
    end

    assign drive_value    = drive_reg;
    assign integral_value = integral_out_reg;

endmodule

`default_nettype wire

[src/pid_controller_step_top.sv]
// Each accepted input beat runs the eight-step microprogram, which puts every product
// through one shared 35x18 multiplier; a zero time step skips one step and a zero
// reciprocal skips two. A new beat is taken only once the previous one reaches its final
// step, and the next beat is taken while the last result waits.
// Reset: asynchronous active low; clears the integral and the previous error and restores
// the gain, time step and reciprocal registers to their default values.
`default_nettype none

module pid_controller_step_top
    import pid_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CfgIdxW-1:0]   cfg_index,
    input  wire logic [CfgW-1:0]      cfg_data,
    pid_in_if.sink                    in_ch,
    pid_out_if.source                 out_ch
);

    cfg_regs_t   cfg_reg;
    logic        out_valid_reg;
    logic        out_stall;
    logic        start;
    logic        seq_ready;
    ctrl_word_t  ctrl;
    dp_status_t  status;

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp  <= KpReset;
            cfg_reg.ki  <= KiReset;
            cfg_reg.kd  <= KdReset;
            cfg_reg.dt  <= DtReset;
            cfg_reg.rdt <= RdtReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KP:  cfg_reg.kp  <= cfg_data;
                CFG_KI:  cfg_reg.ki  <= cfg_data;
                CFG_KD:  cfg_reg.kd  <= cfg_data;
                CFG_DT:  cfg_reg.dt  <= cfg_data;
                CFG_RDT: cfg_reg.rdt <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input handshake
    assign in_ch.ready = seq_ready;
    assign start       = in_ch.valid && seq_ready;

    // Output register valid
    assign out_stall = out_valid_reg && !out_ch.ready;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end
    assign out_ch.valid = out_valid_reg;

    pid_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .out_stall (out_stall),
        .status    (status),
        .ctrl      (ctrl),
        .ready     (seq_ready)
    );

    pid_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (start),
        .target_value   (in_ch.target_value),
        .measured_value (in_ch.measured_value),
        .cfg            (cfg_reg),
        .ctrl           (ctrl),
        .status         (status),
        .drive_value    (out_ch.drive_value),
        .integral_value (out_ch.integral_value)
    );

    // A result is never written over an unread one.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |-> !out_stall)
        else $error("result register overwritten while stalled");

    // Every finished program presents a result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |=> out_valid_reg)
        else $error("finished program produced no result beat");

endmodule

`default_nettype wire

[bench/tb_pid_controller_step_top.sv]
`timescale 1ns / 100ps

module tb_pid_controller_step_top;
    import pid_pkg::*;

    localparam int HalfPeriod   = 6;
    localparam int ResetCycles  = 4;
    localparam int StallLimit   = 2000;
    localparam int SettleCycles = 16;
    localparam int ReportLimit  = 10;
    localparam int IdleModeSpan = 97;
    localparam int HeavyIdlePct = 86;
    localparam int LightIdlePct = 28;
    localparam int WindupBeats  = 1500;
    localparam int RandomPhases = 8;
    localparam int PhaseBeats   = 40;

    // Fixed-point scaling of the drive sum, all terms aligned at Q.16.
    localparam int     DropBits   = 12;
    localparam longint RoundHalf  = 2048;
    localparam longint PropScale  = 256;
    localparam longint IntegScale = 16;
    localparam longint Int32Top    = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Int32Bottom = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic signed [InW-1:0] target;
        logic signed [InW-1:0] measured;
    } pid_sample_t;

    typedef struct packed {
        logic signed [OutW-1:0] drive;
        logic signed [OutW-1:0] integral;
    } pid_result_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgW-1:0]     cfg_data;

    pid_in_if  in_ch();
    pid_out_if out_ch();

    // Mirror of the gain and timing registers.
    logic signed [CfgW-1:0] gain_p;
    logic signed [CfgW-1:0] gain_i;
    logic signed [CfgW-1:0] gain_d;
    logic [CfgW-1:0]        step_dt;
    logic [CfgW-1:0]        step_rdt;

    // Controller state as the block should hold it.
    longint integral_acc;
    longint previous_error;

    pid_sample_t pending_beats[$];
    pid_result_t expected_results[$];
    idle_mode_t  idle_mode;

    int queued_count;
    int accepted_count;
    int result_count;
    int fault_count;
    int setting_count;
    int drive_clamps;
    int integral_clamps;
    int stall_cycles;

    pid_controller_step_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #HalfPeriod clk = 1'b1;
        #HalfPeriod clk = 1'b0;
    end

    function automatic longint clamp_int32(input longint v);
        if (v > Int32Top)
        begin
            return Int32Top;
        end
        else if (v < Int32Bottom)
        begin
            return Int32Bottom;
        end
        return v;
    endfunction

    // One controller step: updates the integral and previous error and
    // returns the drive and integral the block should report.
    function automatic pid_result_t predict_pid_step(input pid_sample_t sample);
        longint      err;
        longint      incr;
        longint      diff;
        longint      sum;
        longint      raw;
        longint      sat;
        pid_result_t result;
        err  = longint'($signed(sample.target)) - longint'($signed(sample.measured));
        incr = (err * longint'(step_dt) + RoundHalf) >>> DropBits;
        raw  = integral_acc + incr;
        sat  = clamp_int32(raw);
        if (sat != raw)
        begin
            integral_clamps++;
        end
        integral_acc = sat;

        diff = err - previous_error;
        sum  = longint'(gain_p) * err * PropScale
             + longint'(gain_i) * integral_acc * IntegScale
             + longint'(gain_d) * diff * longint'(step_rdt);
        raw  = (sum + RoundHalf) >>> DropBits;
        sat  = clamp_int32(raw);
        if (sat != raw)
        begin
            drive_clamps++;
        end
        previous_error = err;

        result.drive    = OutW'(sat);
        result.integral = OutW'(integral_acc);
        return result;
    endfunction

    // Input driver: presents queued samples, holds each until it is taken.
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        pid_sample_t beat;
        if (!rst_n)
        begin
            in_ch.valid          <= 1'b0;
            in_ch.target_value   <= '0;
            in_ch.measured_value <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(predict_pid_step(
                    pid_sample_t'({in_ch.target_value, in_ch.measured_value})));
                accepted_count++;
                idle_mode <= idle_mode_t'((accepted_count / IdleModeSpan) % 4);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >=
                    ((idle_mode == IDLE_SENDER) ? HeavyIdlePct :
                     (idle_mode == IDLE_BOTH) ? LightIdlePct : 0))
                begin
                    beat = pending_beats.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.target_value   <= beat.target;
                    in_ch.measured_value <= beat.measured;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks every result beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        pid_result_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= ReportLimit)
                    begin
                        $display("Unexpected result beat: drive %0d integral %0d",
                                 out_ch.drive_value, out_ch.integral_value);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_ch.drive_value !== want.drive ||
                        out_ch.integral_value !== want.integral)
                    begin
                        fault_count++;
                        if (fault_count <= ReportLimit)
                        begin
                            $display("Beat %0d: drive expected %0d got %0d, integral expected %0d got %0d",
                                     result_count, want.drive, out_ch.drive_value,
                                     want.integral, out_ch.integral_value);
                        end
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >=
                ((idle_mode == IDLE_RECEIVER) ? HeavyIdlePct :
                 (idle_mode == IDLE_BOTH) ? LightIdlePct : 0));
        end
    end

    // Watchdog: ends the run when work is outstanding but no beat moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((accepted_count != queued_count || expected_results.size() != 0) &&
                !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready))
            begin
                stall_cycles++;
            end
            else
            begin
                stall_cycles = 0;
            end
            if (stall_cycles >= StallLimit)
            begin
                $display("No beat moved for %0d cycles with %0d results outstanding",
                         stall_cycles, expected_results.size());
                $display("[pid_controller_step_top] ERROR");
                $finish;
            end
        end
    end

    task automatic queue_sample(input int target, input int measured);
        pending_beats.push_back('{InW'(target), InW'(measured)});
        queued_count++;
    endtask

    // Writes one register and keeps the mirror in step; unknown indexes are ignored.
    task automatic write_register(input logic [CfgIdxW-1:0] index, input logic [CfgW-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            CFG_KP:  gain_p   = value;
            CFG_KI:  gain_i   = value;
            CFG_KD:  gain_d   = value;
            CFG_DT:  step_dt  = value;
            CFG_RDT: step_rdt = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int kp, input int ki, input int kd,
                              input int dt, input int rdt);
        write_register(CFG_KP, CfgW'(kp));
        write_register(CFG_KI, CfgW'(ki));
        write_register(CFG_KD, CfgW'(kd));
        write_register(CFG_DT, CfgW'(dt));
        write_register(CFG_RDT, CfgW'(rdt));
        setting_count++;
        @(negedge clk);
    endtask

    // Waits until every sample is taken and every result is back, then lets
    // the pipeline settle.
    task automatic drain();
        while (accepted_count != queued_count || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SettleCycles) @(negedge clk);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
        endcase
    endfunction

    function automatic int random_gain();
        if ($urandom_range(3) == 0)
        begin
            return int'($urandom_range(512)) - 256;
        end
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic int random_step();
        if ($urandom_range(5) == 0)
        begin
            return 0;
        end
        return $urandom_range(1) ? int'($urandom_range(65535)) : int'($urandom_range(512));
    endfunction

    initial
    begin : stimulus
        int t;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.target_value   = '0;
        in_ch.measured_value = '0;
        out_ch.ready         = 1'b0;
        gain_p               = KpReset;
        gain_i               = KiReset;
        gain_d               = KdReset;
        step_dt              = DtReset;
        step_rdt             = RdtReset;
        integral_acc         = 0;
        previous_error       = 0;
        idle_mode            = IDLE_NONE;
        setting_count        = 1;

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default registers: field extremes and swings of the error.
        queue_sample(32767, -32768);
        queue_sample(-32768, 32767);
        queue_sample(32767, -32768);
        queue_sample(0, 0);
        queue_sample(-32768, -32768);
        queue_sample(32767, 32767);
        queue_sample(1, 0);
        queue_sample(0, 1);
        queue_sample(-1, 0);
        queue_sample(0, -1);
        queue_sample(-32768, 0);
        queue_sample(0, -32768);
        drain();

        // Zero time step and zero reciprocal; writes past the last register
        // must leave everything alone.
        set_config(KpReset, KiReset, KdReset, 0, 0);
        for (int n = 1; n <= 3; n++)
        begin
            write_register(CfgIdxW'(int'(CFG_RDT) + n), '1);
        end
        @(negedge clk);
        queue_sample(100, -200);
        queue_sample(-4000, 4000);
        queue_sample(32767, -32768);
        drain();

        // Largest gains and timing: the drive saturates both ways.
        set_config(32767, 32767, 32767, 65535, 65535);
        queue_sample(32767, -32768);
        queue_sample(-32768, 32767);
        queue_sample(32767, -32768);
        queue_sample(-32768, 32767);
        drain();

        // Most negative gains and the smallest time step.
        set_config(-32768, -32768, -32768, 1, 1);
        queue_sample(32767, -32768);
        queue_sample(-32768, 32767);
        queue_sample(0, 0);
        queue_sample(1, -1);
        drain();

        // Integral windup: a near-full error at the longest time step
        // winds the integral far up toward its upper limit.
        set_config(random_gain(), random_gain(), random_gain(), 65535, random_step());
        for (int n = 0; n < WindupBeats; n++)
        begin
            queue_sample(int'($urandom_range(32767, 32750)),
                         -int'($urandom_range(32768, 32750)));
        end
        drain();

        // Random register settings with mixed samples; the last phase
        // returns to the default registers.
        for (int p = 0; p < RandomPhases; p++)
        begin
            if (p == RandomPhases - 1)
            begin
                set_config(KpReset, KiReset, KdReset, DtReset, RdtReset);
            end
            else
            begin
                set_config(random_gain(), random_gain(), random_gain(),
                           random_step(), random_step());
            end
            for (int n = 0; n < PhaseBeats; n++)
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        queue_sample(int'($urandom), int'($urandom));
                    end
                    1:
                    begin
                        queue_sample(pick_extreme(), pick_extreme());
                    end
                    default:
                    begin
                        // Measurement tracking the setpoint closely.
                        t = int'($urandom_range(65535)) - 32768;
                        queue_sample(t, t + int'($urandom_range(256)) - 128);
                    end
                endcase
            end
            drain();
        end

        $display("Checked %0d result beats from %0d samples over %0d register settings,",
                 result_count, accepted_count, setting_count);
        $display("with sender and receiver idling; integral clamped %0d times, drive %0d times.",
                 integral_clamps, drive_clamps);
        if (fault_count == 0)
        begin
            $display("[pid_controller_step_top] OK");
        end
        else
        begin
            $display("[pid_controller_step_top] ERROR");
        end
        $finish;
    end

endmodule
